// ----- sv/cbf_pkg.sv -----
package cbf_pkg;

  // Field and register widths
  localparam int HASH_W       = 64;
  localparam int OP_W         = 2;
  localparam int COUNT_W      = 8;
  localparam int TABLE_SIZE_W = 13;
  localparam int HASH_COUNT_W = 5;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  // Parameter defaults
  localparam int MAX_COUNTERS_DEF = 4096;
  localparam int MAX_HASHES_DEF   = 16;

  // Register reset values
  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 13'd4096;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 5'd7;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HASH_COUNT = 1'd1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Counter saturation value
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

endpackage

// ----- sv/cbf_ram.sv -----
module cbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/counting_bloom_filter.sv -----
// Counting Bloom filter over a RAM of 8-bit counters.
// Input channel (in_valid/in_ready) carries op, first_hash and second_hash;
// output channel (out_valid/out_ready) returns one present bit per item.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 table_size, 1 hash_count); write only while the block is idle.
// One item is processed at a time. After the transfer, three bit-serial
// remainder units run in parallel to reduce first_hash, second_hash and
// 2^64 by the table size. Each of the k indexes then takes a RAM read,
// then a modify and write back, and the next index is stepped forward
// from the last remainder; k is the used hash count.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, a finished item holds until the result register
// frees up, and no new item is taken meanwhile.
// Reset starts a clearing pass that zeroes the counter RAM; in_ready stays
// low until it ends. Configuration writes are taken during the pass.
module counting_bloom_filter #(
  parameter int MAX_COUNTERS = cbf_pkg::MAX_COUNTERS_DEF,
  parameter int MAX_HASHES   = cbf_pkg::MAX_HASHES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cbf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cbf_pkg::OP_W-1:0]          op,
  input  logic [cbf_pkg::HASH_W-1:0]        first_hash,
  input  logic [cbf_pkg::HASH_W-1:0]        second_hash,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              present
);

  import cbf_pkg::*;

  localparam int AW = $clog2(MAX_COUNTERS);
  localparam int KW = $clog2(MAX_HASHES + 1);
  localparam int BW = $clog2(HASH_W);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]              state;
  logic [TABLE_SIZE_W-1:0] table_size;
  logic [HASH_COUNT_W-1:0] hash_count;
  logic [AW-1:0]           clr_addr;
  logic [OP_W-1:0]         op_q;
  logic [HASH_W-1:0]       h1_q;
  logic [HASH_W-1:0]       h2_q;
  logic [HASH_W-1:0]       s;
  logic [BW-1:0]           bitcnt;
  logic [AW-1:0]           r1;
  logic [AW-1:0]           r2;
  logic [AW-1:0]           rc;
  logic [AW-1:0]           wrap_rem;
  logic [AW-1:0]           ridx;
  logic [AW-1:0]           waddr;
  logic [KW-1:0]           hcnt;
  logic                    present_acc;

  logic [AW:0]             m;
  logic [KW-1:0]           k;
  logic [HASH_W:0]         sum;
  logic                    is_update;
  logic [AW:0]             rc_inc;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [COUNT_W-1:0]      ram_wdata;
  logic [COUNT_W-1:0]      rdata;
  logic [COUNT_W-1:0]      cnt_next;

  // One restoring remainder step: shift in a dividend bit, subtract if due
  function automatic logic [AW-1:0] mod_step(input logic [AW-1:0] r, input logic b,
                                             input logic [AW:0] mod);
    logic [AW:0] t;
    t = {r, b};
    if (t >= mod) begin
      t = t - mod;
    end
    return t[AW-1:0];
  endfunction

  // Step an index by the stride remainder, correcting for a 64-bit wrap
  function automatic logic [AW-1:0] idx_step(input logic [AW-1:0] r, input logic [AW-1:0] a,
                                             input logic [AW-1:0] c, input logic [AW:0] mod,
                                             input logic carry);
    logic [AW:0] t;
    t = {1'b0, r} + {1'b0, a};
    if (t >= mod) begin
      t = t - mod;
    end
    if (carry) begin
      if (t >= {1'b0, c}) begin
        t = t - {1'b0, c};
      end else begin
        t = t + mod - {1'b0, c};
      end
    end
    return t[AW-1:0];
  endfunction

  // Clamp the configured table size and hash count
  always_comb begin
    if (table_size == '0) begin
      m = (AW+1)'(1);
    end else if (32'(table_size) > 32'(MAX_COUNTERS)) begin
      m = (AW+1)'(MAX_COUNTERS);
    end else begin
      m = (AW+1)'(table_size);
    end
    if (32'(hash_count) > 32'(MAX_HASHES)) begin
      k = KW'(MAX_HASHES);
    end else begin
      k = KW'(hash_count);
    end
  end

  assign sum       = {1'b0, s} + {1'b0, h2_q};
  assign is_update = (op_q == OP_INSERT) || (op_q == OP_REMOVE);
  assign rc_inc    = {1'b0, rc} + (AW+1)'(1);
  assign in_ready  = (state == ST_IDLE);

  // Saturating counter update
  always_comb begin
    cnt_next = rdata;
    if (op_q == OP_INSERT) begin
      if (rdata != COUNT_MAX) begin
        cnt_next = rdata + COUNT_W'(1);
      end
    end else if (rdata != '0) begin
      cnt_next = rdata - COUNT_W'(1);
    end
  end

  // RAM write port: clearing pass or write-back
  always_comb begin
    if (state == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == ST_WR) && is_update;
      ram_waddr = waddr;
      ram_wdata = cnt_next;
    end
  end

  cbf_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_COUNTERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ridx),
    .rdata (rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RST;
      hash_count <= HASH_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_SIZE: table_size <= cfg_data[TABLE_SIZE_W-1:0];
        CFG_HASH_COUNT: hash_count <= cfg_data[HASH_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clear, reduce hashes, walk the indexes, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result after its transfer unless a new one is loaded
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          if (clr_addr == AW'(MAX_COUNTERS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_q   <= op;
            h1_q   <= first_hash;
            h2_q   <= second_hash;
            r1     <= '0;
            r2     <= '0;
            rc     <= '0;
            bitcnt <= BW'(HASH_W - 1);
            state  <= ST_MOD;
          end
        end
        ST_MOD: begin
          r1 <= mod_step(r1, h1_q[bitcnt], m);
          r2 <= mod_step(r2, h2_q[bitcnt], m);
          rc <= mod_step(rc, 1'b1, m);
          if (bitcnt == '0) begin
            state <= ST_PREP;
          end else begin
            bitcnt <= bitcnt - BW'(1);
          end
        end
        ST_PREP: begin
          wrap_rem    <= (rc_inc == m) ? '0 : rc_inc[AW-1:0];
          ridx        <= r1;
          s           <= h1_q;
          hcnt        <= '0;
          present_acc <= (op_q == OP_QUERY);
          if ((is_update || op_q == OP_QUERY) && k != '0) begin
            state <= ST_RD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_RD: begin
          waddr <= ridx;
          ridx  <= idx_step(ridx, r2, wrap_rem, m, sum[HASH_W]);
          s     <= sum[HASH_W-1:0];
          state <= ST_WR;
        end
        ST_WR: begin
          if (op_q == OP_QUERY && rdata == '0) begin
            present_acc <= 1'b0;
          end
          hcnt <= hcnt + KW'(1);
          if (hcnt + KW'(1) == k) begin
            state <= ST_FIN;
          end else begin
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            present   <= present_acc;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/cbf_checker.sv -----
module cbf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic present
);

  // Reset starts the clearing pass with no result pending
  a_reset_quiet: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("input ready or result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(present))
    else $error("stalled result dropped or changed");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // A new result appears only after the input side was busy
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while input side was idle");

endmodule

bind counting_bloom_filter cbf_checker u_chk (.*);

// ----- sim/bloom_checker.sv -----
`timescale 1ns / 1ps
module bloom_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [cbf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [cbf_pkg::OP_W-1:0] op,
  input  logic [cbf_pkg::HASH_W-1:0] first_hash,
  input  logic [cbf_pkg::HASH_W-1:0] second_hash,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     present,
  output int                       fail_count,
  output int                       pending
);
  import cbf_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int IW          = $clog2(MAX_COUNTERS_DEF);

  // Shadow copy of the counter RAM and the two registers
  logic [COUNT_W-1:0]      shadow_counts [MAX_COUNTERS_DEF];
  logic [TABLE_SIZE_W-1:0] size_reg;
  logic [HASH_COUNT_W-1:0] hashes_reg;
  bit                      expected_present [$];
  bit                      want;

  // Walk the double-hash indexes, update the shadow counters, return the answer
  function automatic bit predict_present(input logic [OP_W-1:0] code,
                                         input logic [HASH_W-1:0] h1,
                                         input logic [HASH_W-1:0] h2);
    logic [HASH_W-1:0] m;
    logic [HASH_W-1:0] k;
    logic [HASH_W-1:0] i;
    logic [IW-1:0]     slot;
    bit                hit;
    if (size_reg == 0) m = 1;
    else if (size_reg > MAX_COUNTERS_DEF) m = MAX_COUNTERS_DEF;
    else m = size_reg;
    k = (hashes_reg > MAX_HASHES_DEF) ? MAX_HASHES_DEF : hashes_reg;
    hit = (code == OP_QUERY);
    for (i = 0; i < k; i = i + 1) begin
      slot = IW'((h1 + i * h2) % m);
      case (code)
        OP_INSERT: begin
          if (shadow_counts[slot] != COUNT_MAX) shadow_counts[slot] = shadow_counts[slot] + 1'b1;
        end
        OP_REMOVE: begin
          if (shadow_counts[slot] != 0) shadow_counts[slot] = shadow_counts[slot] - 1'b1;
        end
        OP_QUERY: begin
          if (shadow_counts[slot] == 0) hit = 1'b0;
        end
        default: ;
      endcase
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_COUNTERS_DEF; j++) shadow_counts[j] = '0;
      size_reg = TABLE_SIZE_RST;
      hashes_reg = HASH_COUNT_RST;
      expected_present.delete();
      fail_count = 0;
    end else begin
      // track register writes
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_TABLE_SIZE: size_reg = cfg_data[TABLE_SIZE_W-1:0];
          CFG_HASH_COUNT: hashes_reg = cfg_data[HASH_COUNT_W-1:0];
          default: ;
        endcase
      end
      // compare a result transfer against the oldest prediction
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_present.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: result with nothing outstanding, present=%0b", $time, present);
          fail_count++;
        end else begin
          want = expected_present.pop_front();
          if (present !== want) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: present mismatch, expected %0b, got %0b", $time, want, present);
            fail_count++;
          end
        end
      end
      // predict each input transfer
      if (in_valid === 1'b1 && in_ready === 1'b1)
        expected_present.push_back(predict_present(op, first_hash, second_hash));
    end
    pending = expected_present.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import cbf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int KEYS        = 6;
  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 120;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         op;
  logic [HASH_W-1:0]       first_hash;
  logic [HASH_W-1:0]       second_hash;
  logic                    out_valid;
  logic                    out_ready;
  logic                    present;
  logic                    drain_ready;
  logic                    hold_off;
  logic                    start_hold;
  logic                    quiet;
  int                      fail_count;
  int                      pending;
  logic [HASH_W-1:0]       pool_first [KEYS];
  logic [HASH_W-1:0]       pool_second [KEYS];

  assign out_ready = drain_ready & ~hold_off;

  counting_bloom_filter uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .first_hash (first_hash),
    .second_hash(second_hash),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .present    (present)
  );

  bloom_checker bloom_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .first_hash (first_hash),
    .second_hash(second_hash),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .present    (present),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("counting_bloom_filter verification failed");
    $finish;
  end

  // Result side: random stall before each transfer
  initial begin : drain
    int gap;
    drain_ready = 1'b0;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        drain_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      drain_ready = 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
      @(negedge clk);
    end
  end

  // Hold off results for a long stretch so the block backs up
  initial begin : long_stall
    hold_off = 1'b0;
    wait (start_hold);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  function automatic logic [HASH_W-1:0] rand64();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one item after a random gap; return at the negedge after the transfer
  task automatic send_item(input logic [OP_W-1:0] code,
                           input logic [HASH_W-1:0] h1,
                           input logic [HASH_W-1:0] h2);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid = 1'b0;
      first_hash = {$urandom, $urandom};
      second_hash = {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    op = code;
    first_hash = h1;
    second_hash = h2;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One setting of the registers, then mostly operations on a small key pool
  task automatic run_phase(input int size,
                           input int hashes,
                           input bit calm, input bit stall);
    int r;
    int slot;
    int s;
    int n;
    logic [OP_W-1:0] code;
    wait_drained();
    write_reg(CFG_TABLE_SIZE, CFG_DATA_W'(size));
    write_reg(CFG_HASH_COUNT, CFG_DATA_W'(hashes));
    quiet = calm;
    for (s = 0; s < KEYS; s++) begin
      pool_first[s] = rand64();
      pool_second[s] = rand64();
    end
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (stall && n == 10) start_hold = 1'b1;
      r = $urandom_range(0, 99);
      slot = $urandom_range(0, KEYS - 1);
      if (r < 40) begin
        send_item(OP_INSERT, pool_first[slot], pool_second[slot]);
      end else if (r < 60) begin
        send_item(OP_REMOVE, pool_first[slot], pool_second[slot]);
      end else if (r < 90) begin
        send_item(OP_QUERY, pool_first[slot], pool_second[slot]);
      end else if (r < 96) begin
        code = OP_W'($urandom_range(OP_INSERT, OP_QUERY));
        send_item(code, rand64(), rand64());
      end else begin
        send_item(OP_UNUSED, rand64(), rand64());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_TABLE_SIZE;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_INSERT;
    first_hash = '0;
    second_hash = '0;
    quiet = 1'b0;
    start_hold = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty filter, then one key in and out, remove at zero
    send_item(OP_QUERY, '0, '0);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_QUERY, '1, '1);
    send_item(OP_REMOVE, '1, '1);
    send_item(OP_REMOVE, '1, '1);
    send_item(OP_QUERY, '1, '1);
    send_item(OP_INSERT, '0, '0);

    // zero table size acts as one counter; oversized hash count: saturate counter 0
    wait_drained();
    write_reg(CFG_TABLE_SIZE, '0);
    write_reg(CFG_HASH_COUNT, CFG_DATA_W'(31));
    for (n = 0; n < 16; n++) send_item(OP_INSERT, rand64(), rand64());
    send_item(OP_QUERY, rand64(), rand64());

    // oversized table, no hashes, unused op code
    wait_drained();
    write_reg(CFG_TABLE_SIZE, '1);
    write_reg(CFG_HASH_COUNT, '0);
    send_item(OP_QUERY, rand64(), rand64());
    send_item(OP_INSERT, rand64(), rand64());
    send_item(OP_UNUSED, '1, '1);

    // random phases over several register settings
    run_phase(1, 16, 1'b0, 1'b0);
    run_phase(4096, 7, 1'b0, 1'b1);
    run_phase(8, 3, 1'b1, 1'b0);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 16), 1'b0, 1'b0);
    run_phase(8191, 20, 1'b0, 1'b0);
    run_phase($urandom_range(0, 8191), $urandom_range(0, 31), 1'b0, 1'b0);
    run_phase(2, 1, 1'b1, 1'b0);
    run_phase(4095, 16, 1'b0, 1'b0);

    // drain, then watch for stray results
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("counting_bloom_filter verification clean");
    end else begin
      $display("counting_bloom_filter verification failed");
    end
    $finish;
  end

endmodule
